### rtl/cdrf_pkg.sv
// Shared types and constants for the CAN datagram receive filter.
// Holds the item structs, register indexes and filter configuration types.
// Depends on nothing; every other file imports it.
`default_nettype none

package cdrf_pkg;

  localparam int MAX_FRAME_BYTES = 64;
  localparam int LEN_PREFIX_BYTES = 1;
  localparam logic [31:0] SENDER_FIELD_MASK = 32'h1FFF_FFFF;
  localparam logic [5:0] BUFFER_LIMIT_RESET = 6'd63;
  localparam logic [6:0] POSITION_MAX = 7'd127;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IDENTIFIER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MASK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_LIMIT = 2'd3;

  typedef struct packed {
    logic [31:0] frame_identifier;
    logic [6:0]  frame_length;
    logic        frame_bad;
    logic [7:0]  data_byte;
    logic        frame_start;
    logic        frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        byte_present;
    logic [28:0] sender_id;
    logic [5:0]  datagram_length;
    logic        datagram_last;
  } out_item_t;

  typedef struct packed {
    logic [31:0] own_identifier;
    logic [31:0] accept_match;
    logic [31:0] accept_mask;
    logic [5:0]  buffer_limit;
  } filter_cfg_t;

  typedef struct packed {
    logic        accept;
    logic [28:0] sender;
    logic [5:0]  length;
  } verdict_t;

endpackage

`default_nettype wire

### rtl/cdrf_in_if.sv
// Input channel of the CAN datagram receive filter: valid, ready and one frame byte item.
// Depends on cdrf_pkg for the item type.
`default_nettype none

interface cdrf_in_if import cdrf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/cdrf_out_if.sv
// Result channel of the CAN datagram receive filter: valid, ready and one datagram byte item.
// Depends on cdrf_pkg for the item type.
`default_nettype none

interface cdrf_out_if import cdrf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

### rtl/cdrf_accept_filter.sv
// Frame acceptance test applied to the first item of a CAN frame.
// Depends on cdrf_pkg for the item, configuration and verdict types.
`default_nettype none

module cdrf_accept_filter import cdrf_pkg::*; (
  input  in_item_t    item,
  input  filter_cfg_t cfg,
  output verdict_t    verdict
);

  logic [31:0] sender_w;
  logic        own_hit;
  logic        mask_fail;
  logic        len_fail;
  logic        prefix_fail;
  logic [6:0]  payload_room;

  assign sender_w = item.frame_identifier & SENDER_FIELD_MASK;
  assign own_hit = (sender_w == cfg.own_identifier);
  assign mask_fail = (cfg.accept_mask != 32'd0) &&
                     ((sender_w & cfg.accept_mask) != cfg.accept_match);
  assign len_fail = (item.frame_length < 7'(LEN_PREFIX_BYTES)) ||
                    (item.frame_length > 7'(MAX_FRAME_BYTES));
  // Only meaningful when the frame holds at least the prefix byte.
  assign payload_room = item.frame_length - 7'(LEN_PREFIX_BYTES);
  assign prefix_fail = (item.data_byte > {1'b0, payload_room}) ||
                       (item.data_byte > {2'b00, cfg.buffer_limit});

  assign verdict.accept = !item.frame_bad && !own_hit && !mask_fail && !len_fail &&
                          !prefix_fail;
  assign verdict.sender = sender_w[28:0];
  assign verdict.length = item.data_byte[5:0];

endmodule

`default_nettype wire

### rtl/can_datagram_rx_filter_core.sv
// Top level of the CAN datagram receive filter and deframer.
// Depends on cdrf_pkg, cdrf_in_if, cdrf_out_if and cdrf_accept_filter.
//
// Frames arrive on in_chan one data byte per item, each item repeating the
// frame's raw identifier, length and error mark. The first item carries the
// length prefix and decides acceptance: error frames, frames from our own
// identifier, frames failing the mask and match test, empty or oversized
// frames and frames whose prefix exceeds the payload or buffer_limit are
// dropped silently. Accepted datagram bytes leave on out_chan with the sender
// and the length, the last one flagged; an empty datagram gives one item with
// byte_present 0. Padding bytes produce nothing. Registers are written via
// cfg_we, cfg_index, cfg_wdata; the user must write only while idle, unchecked.
//
// An item is registered at acceptance in the input register and its result
// then enters the output register, from which it leaves on out_chan.
// One item per cycle is sustained while out_chan is ready. When out_chan
// stalls, the output register holds, the input register takes one more item
// and holds it, and then in_chan.ready drops.
// Reset clears the frame state and loads the register reset values.
`default_nettype none

module can_datagram_rx_filter_core import cdrf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  cdrf_in_if.sink                   in_chan,
  cdrf_out_if.source                out_chan,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata
);

  filter_cfg_t cfg_r;

  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      s1_adv;
  logic      in_take;

  logic        acc_r, acc_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic [5:0]  hlen_r, hlen_nxt;
  logic [28:0] hsend_r, hsend_nxt;

  logic      emit;
  out_item_t emit_item;
  logic      out_valid_r;
  out_item_t out_item_r;

  verdict_t verdict;

  cdrf_accept_filter u_filter (
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .verdict (verdict)
  );

  assign s1_adv = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_take = in_chan.valid && in_chan.ready;

  assign out_chan.valid = out_valid_r;
  assign out_chan.item = out_item_r;

  always_comb begin
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    hlen_nxt = hlen_r;
    hsend_nxt = hsend_r;
    emit = 1'b0;
    emit_item.payload_byte = 8'd0;
    emit_item.byte_present = 1'b0;
    emit_item.sender_id = hsend_r;
    emit_item.datagram_length = hlen_r;
    emit_item.datagram_last = 1'b0;
    if (s1_item_r.frame_start) begin
      acc_nxt = 1'b0;
      pos_nxt = 7'd1;
      if (verdict.accept) begin
        hsend_nxt = verdict.sender;
        hlen_nxt = verdict.length;
        emit_item.sender_id = verdict.sender;
        emit_item.datagram_length = verdict.length;
        if (verdict.length == 6'd0) begin
          // Empty datagram: a single marker item.
          emit = 1'b1;
          emit_item.datagram_last = 1'b1;
        end else begin
          acc_nxt = 1'b1;
        end
      end
    end else if (acc_r) begin
      if ((pos_r >= 7'd1) && (pos_r <= {1'b0, hlen_r})) begin
        emit = 1'b1;
        emit_item.payload_byte = s1_item_r.data_byte;
        emit_item.byte_present = 1'b1;
        emit_item.datagram_last = (pos_r == {1'b0, hlen_r});
        if (pos_r == {1'b0, hlen_r}) begin
          acc_nxt = 1'b0;
        end
      end
      if (pos_r < POSITION_MAX) begin
        pos_nxt = pos_r + 7'd1;
      end
    end
    if (s1_item_r.frame_end) begin
      acc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_identifier <= 32'd0;
      cfg_r.accept_match <= 32'd0;
      cfg_r.accept_mask <= 32'd0;
      cfg_r.buffer_limit <= BUFFER_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OWN_IDENTIFIER: cfg_r.own_identifier <= cfg_wdata;
        CFG_ACCEPT_MATCH:   cfg_r.accept_match <= cfg_wdata;
        CFG_ACCEPT_MASK:    cfg_r.accept_mask <= cfg_wdata;
        CFG_BUFFER_LIMIT:   cfg_r.buffer_limit <= cfg_wdata[5:0];
        default:            cfg_r <= cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r <= 1'b0;
      pos_r <= 7'd0;
      hlen_r <= 6'd0;
      hsend_r <= 29'd0;
    end else begin
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= emit;
        acc_r <= acc_nxt;
        pos_r <= pos_nxt;
        hlen_r <= hlen_nxt;
        hsend_r <= hsend_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_chan.item;
    end
    if (s1_adv && emit) begin
      out_item_r <= emit_item;
    end
  end

endmodule

`default_nettype wire

### tb/deframe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the CAN datagram receive filter: watches both channels and the register port.
// Predicts each datagram byte from the accepted frame items and compares it with the block's result.
// Depends on cdrf_pkg, cdrf_in_if and cdrf_out_if.

module deframe_checker import cdrf_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  cdrf_in_if                        in_mon,
  cdrf_out_if                       out_mon,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_wdata,
  output int                        mismatch_count,
  output int                        datagram_bytes_due
);

  filter_cfg_t filter_cfg;
  bit          in_datagram;
  bit [6:0]    frame_pos;
  bit [5:0]    dg_length;
  bit [28:0]   dg_sender;
  out_item_t   datagram_bytes_q[$];

  function automatic void emit_byte(logic [7:0] b, logic present, logic last);
    out_item_t r;
    r.payload_byte    = b;
    r.byte_present    = present;
    r.sender_id       = dg_sender;
    r.datagram_length = dg_length;
    r.datagram_last   = last;
    datagram_bytes_q.push_back(r);
  endfunction

  function automatic void advance_deframer(in_item_t it);
    logic [31:0] sender;
    int          flen;
    int          prefix;
    bit          ok;
    sender = {3'b000, it.frame_identifier[28:0]};
    flen   = int'(it.frame_length);
    prefix = int'(it.data_byte);
    if (it.frame_start) begin
      in_datagram = 1'b0;
      ok = !it.frame_bad && (sender != filter_cfg.own_identifier);
      if (filter_cfg.accept_mask != '0 &&
          (sender & filter_cfg.accept_mask) != filter_cfg.accept_match) ok = 1'b0;
      if (flen < LEN_PREFIX_BYTES || flen > MAX_FRAME_BYTES) ok = 1'b0;
      if (ok && (prefix > flen - LEN_PREFIX_BYTES || prefix > int'(filter_cfg.buffer_limit)))
        ok = 1'b0;
      frame_pos = 7'd1;
      if (ok) begin
        dg_sender = sender[28:0];
        dg_length = it.data_byte[5:0];
        // A zero prefix yields a single marker item and no byte stream.
        if (dg_length == 6'd0) emit_byte(8'h00, 1'b0, 1'b1);
        else in_datagram = 1'b1;
      end
    end else if (in_datagram) begin
      if (frame_pos >= 7'd1 && frame_pos <= {1'b0, dg_length}) begin
        emit_byte(it.data_byte, 1'b1, frame_pos == {1'b0, dg_length});
        if (frame_pos == {1'b0, dg_length}) in_datagram = 1'b0;
      end
      if (frame_pos < POSITION_MAX) frame_pos++;
    end
    if (it.frame_end) in_datagram = 1'b0;
  endfunction

  function automatic void check_datagram_byte(out_item_t got);
    out_item_t exp;
    if (datagram_bytes_q.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result byte=%h present=%b sender=%h len=%0d last=%b",
                 $realtime, got.payload_byte, got.byte_present, got.sender_id,
                 got.datagram_length, got.datagram_last);
      return;
    end
    exp = datagram_bytes_q.pop_front();
    if (got.payload_byte !== exp.payload_byte || got.byte_present !== exp.byte_present ||
        got.sender_id !== exp.sender_id || got.datagram_length !== exp.datagram_length ||
        got.datagram_last !== exp.datagram_last) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: mismatch expected byte=%h present=%b sender=%h len=%0d last=%b",
                 $realtime, exp.payload_byte, exp.byte_present, exp.sender_id,
                 exp.datagram_length, exp.datagram_last);
        $display("%0t:          actual   byte=%h present=%b sender=%h len=%0d last=%b",
                 $realtime, got.payload_byte, got.byte_present, got.sender_id,
                 got.datagram_length, got.datagram_last);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      filter_cfg.own_identifier <= '0;
      filter_cfg.accept_match   <= '0;
      filter_cfg.accept_mask    <= '0;
      filter_cfg.buffer_limit   <= BUFFER_LIMIT_RESET;
      in_datagram    = 1'b0;
      frame_pos      = '0;
      dg_length      = '0;
      dg_sender      = '0;
      datagram_bytes_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_IDENTIFIER: filter_cfg.own_identifier <= cfg_wdata;
          CFG_ACCEPT_MATCH:   filter_cfg.accept_match   <= cfg_wdata;
          CFG_ACCEPT_MASK:    filter_cfg.accept_mask    <= cfg_wdata;
          CFG_BUFFER_LIMIT:   filter_cfg.buffer_limit   <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      // Results are checked before new items are predicted, so a result can
      // never be matched against an item taken on the same edge.
      if (out_mon.valid && out_mon.ready) check_datagram_byte(out_mon.item);
      if (in_mon.valid && in_mon.ready) advance_deframer(in_mon.item);
    end
    datagram_bytes_due = datagram_bytes_q.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the CAN datagram receive filter testbench: clock, reset, frame stimulus and verdict.
// Depends on cdrf_pkg, the channel interfaces, can_datagram_rx_filter_core and deframe_checker.

module tb_top;
  import cdrf_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;
  int                   mismatches;
  int                   bytes_due;

  bit          tx_idle_on;
  bit          rx_idle_on;
  bit          hold_req;
  int          items_sent;
  logic [31:0] cur_own;
  logic [31:0] cur_match;
  logic [31:0] cur_mask;
  int          cur_limit;

  cdrf_in_if  in_chan ();
  cdrf_out_if out_chan ();

  can_datagram_rx_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  deframe_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mon             (in_chan),
    .out_mon            (out_chan),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .mismatch_count     (mismatches),
    .datagram_bytes_due (bytes_due)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off on request.
  initial begin
    out_chan.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_chan.ready <= 1'b0;
        repeat (200) @(negedge clk);
        out_chan.ready <= 1'b1;
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_item(input in_item_t it);
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.item  <= it;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [31:0] ident, input int flen, input bit bad,
                            input logic [7:0] prefix, input int n_items, input bit with_end);
    in_item_t it;
    for (int k = 0; k < n_items; k++) begin
      it.frame_identifier = ident;
      it.frame_length     = flen[6:0];
      it.frame_bad        = bad;
      it.data_byte        = (k == 0) ? prefix : 8'($urandom);
      it.frame_start      = (k == 0);
      it.frame_end        = with_end && (k == n_items - 1);
      offer_item(it);
      items_sent++;
    end
  endtask

  // Items with no frame start; the block ignores them unless an accepted frame is still open.
  task automatic send_strays(input int n);
    in_item_t it;
    for (int k = 0; k < n; k++) begin
      it.frame_identifier = $urandom;
      it.frame_length     = 7'($urandom);
      it.frame_bad        = 1'($urandom);
      it.data_byte        = 8'($urandom);
      it.frame_start      = 1'b0;
      it.frame_end        = 1'($urandom);
      offer_item(it);
      items_sent++;
    end
  endtask

  task automatic apply_filter_setup(input logic [31:0] own, input logic [31:0] match,
                                    input logic [31:0] mask, input int limit);
    cur_own   = own;
    cur_match = match;
    cur_mask  = mask;
    cur_limit = limit;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OWN_IDENTIFIER;
    cfg_wdata <= own;
    @(negedge clk);
    cfg_index <= CFG_ACCEPT_MATCH;
    cfg_wdata <= match;
    @(negedge clk);
    cfg_index <= CFG_ACCEPT_MASK;
    cfg_wdata <= mask;
    @(negedge clk);
    cfg_index <= CFG_BUFFER_LIMIT;
    cfg_wdata <= 32'(limit);
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Waits until every predicted byte is out, then lets the pipeline empty.
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (bytes_due != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [28:0] pick_sender();
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 99);
    if (r < 10) v = cur_own;
    else if (cur_mask != '0 && r < 80) v = (cur_match & cur_mask) | ($urandom & ~cur_mask);
    else v = $urandom;
    return v[28:0];
  endfunction

  task automatic random_frame();
    int          kind;
    int          flen;
    int          max_len;
    logic [31:0] ident;
    logic [7:0]  prefix;
    bit          bad;
    kind = $urandom_range(0, 99);
    ident = $urandom;
    ident[28:0] = pick_sender();
    flen = ($urandom_range(0, 4) == 0) ? $urandom_range(13, MAX_FRAME_BYTES)
                                       : $urandom_range(1, 12);
    max_len = (flen - 1 < cur_limit) ? flen - 1 : cur_limit;
    prefix = 8'($urandom_range(0, max_len));
    bad = ($urandom_range(0, 19) == 0);
    if (kind < 62) begin
      send_frame(ident, flen, bad, prefix, flen, 1'b1);
    end else if (kind < 72) begin
      // Frame ends before the datagram is complete, unless the prefix is zero.
      if (prefix == 0) send_frame(ident, flen, bad, prefix, flen, 1'b1);
      else send_frame(ident, flen, bad, prefix, $urandom_range(1, prefix), 1'b1);
    end else if (kind < 80) begin
      // Cut off without an end; the next frame start abandons it.
      send_frame(ident, flen, bad, prefix, $urandom_range(1, flen), 1'b0);
    end else if (kind < 85) begin
      send_strays($urandom_range(1, 3));
    end else if (kind < 89) begin
      send_frame(ident, 0, bad, prefix, 1, 1'b1);
    end else if (kind < 93) begin
      send_frame(ident, $urandom_range(MAX_FRAME_BYTES + 1, 127), bad, prefix,
                 $urandom_range(1, 8), 1'b1);
    end else if (kind < 99) begin
      send_frame(ident, flen, bad, 8'($urandom_range(max_len + 1, 255)), flen, 1'b1);
    end else begin
      // More items than the position counter can hold.
      send_frame(ident, MAX_FRAME_BYTES, bad, prefix, 130, 1'b1);
    end
  endtask

  task automatic random_frames(input int n_items);
    int goal;
    goal = items_sent + n_items;
    while (items_sent < goal) random_frame();
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_chan.valid = 1'b0;
    in_chan.item  = '0;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    cur_own       = '0;
    cur_match     = '0;
    cur_mask      = '0;
    cur_limit     = int'(BUFFER_LIMIT_RESET);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed frames under the reset filter settings.
    send_frame(32'hF234_5678, 3, 1'b0, 8'd2, 3, 1'b1);
    send_frame(32'h0000_0042, 1, 1'b0, 8'd0, 1, 1'b1);
    send_frame(32'h0000_0042, 0, 1'b0, 8'd1, 1, 1'b1);
    send_frame(32'h0000_0042, 2, 1'b1, 8'd1, 2, 1'b1);
    send_frame(32'hE000_0000, 2, 1'b0, 8'd1, 2, 1'b1);
    send_frame(32'h1FFF_FFFF, 2, 1'b0, 8'd2, 2, 1'b1);
    send_frame(32'h0000_0043, MAX_FRAME_BYTES + 1, 1'b0, 8'd1, 2, 1'b1);
    send_strays(1);
    send_frame(32'h0000_0044, 4, 1'b0, 8'd3, 2, 1'b0);
    send_frame(32'h0000_0045, 2, 1'b0, 8'd1, 2, 1'b1);
    send_frame(32'h0000_0046, 5, 1'b0, 8'd4, 2, 1'b1);
    send_frame(32'h0000_0047, 4, 1'b0, 8'd1, 4, 1'b1);
    random_frames(40);
    settle();

    // Long result hold-off while full-size datagrams keep arriving.
    apply_filter_setup($urandom & SENDER_FIELD_MASK, '0, '0, 63);
    hold_req = 1'b1;
    send_frame(32'h0ABC_DEF0, MAX_FRAME_BYTES, 1'b0, 8'd63, MAX_FRAME_BYTES, 1'b1);
    send_frame(32'h1555_5555, MAX_FRAME_BYTES, 1'b0, 8'd63, MAX_FRAME_BYTES, 1'b1);
    random_frames(40);
    settle();

    apply_filter_setup(32'hFFFF_FFFF, $urandom & 32'h1FFF_FF00, 32'h1FFF_FF00, 20);
    cur_match = cur_match & cur_mask;
    apply_filter_setup(cur_own, cur_match, cur_mask, cur_limit);
    random_frames(60);
    settle();

    // Only empty datagrams fit a zero buffer limit.
    apply_filter_setup($urandom & SENDER_FIELD_MASK, $urandom & SENDER_FIELD_MASK,
                       32'hFFFF_FFFF, 0);
    random_frames(60);
    settle();

    // Match bits above the sender field can never be met.
    apply_filter_setup($urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 37);
    random_frames(30);
    settle();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    apply_filter_setup('0, '0, '0, 63);
    random_frames(60);
    settle();
    repeat (20) @(negedge clk);

    if (mismatches == 0 && bytes_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### can_datagram_rx_filter_core.f
rtl/cdrf_pkg.sv
rtl/cdrf_in_if.sv
rtl/cdrf_out_if.sv
rtl/cdrf_accept_filter.sv
rtl/can_datagram_rx_filter_core.sv
tb/deframe_checker.sv
tb/tb_top.sv
